@@ src/apg_pkg.sv @@
// ----------------------------------------------------------------------------
// apg_pkg
// Shared constants, types and the arctangent table of the arc point generator.
// ----------------------------------------------------------------------------
package apg_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int MAX_POINTS   = 64;
    localparam int IDX_W        = $clog2(MAX_POINTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int ANG_IN_W     = 24;
    localparam int WIDE_SH      = 30 - FRAC_BITS;
    localparam int WIDE_W       = ANG_IN_W + WIDE_SH;
    localparam int A_W          = ((WIDE_W > 34) ? WIDE_W : 34) + 2;
    localparam int MOD_STEPS    = (WIDE_W > 33) ? (WIDE_W - 32) : 1;
    localparam int SPAN_W       = 33;
    localparam int CORDIC_STEPS = 28;
    localparam int CW           = 34;
    localparam int ANGC_W       = 36;
    localparam int U_W          = 32;
    localparam int ITER_W       = 6;

    localparam logic [33:0] TWO_PI_Q30  = 34'h1921FB544;
    localparam logic [33:0] PI_Q30      = 34'h0C90FDAA2;
    localparam logic [33:0] HALF_PI_Q30 = 34'h06487ED51;
    localparam logic [31:0] GAIN_INV    = 32'h26DD3B6A;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MOD,
        OP_ADJ0,
        OP_ADJ1,
        OP_ADJ2,
        OP_ADJ3,
        OP_DIV_INIT,
        OP_DIV,
        OP_COR_STEP,
        OP_COR_START,
        OP_COR_WRAP,
        OP_COR_FOLD,
        OP_COR_ITER,
        OP_SAVE_ROT,
        OP_SAVE_UNIT,
        OP_POINT,
        OP_ADVANCE
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [ITER_W-1:0]   iter;
    } dp_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic n_one;
        logic last;
    } dp_stat_t;

    // Arctangent of 2^-i in Q2.30.
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] v;
        begin
            case (i)
                5'd0:  v = 32'h3243F6A8;
                5'd1:  v = 32'h1DAC6705;
                5'd2:  v = 32'h0FADBAFC;
                5'd3:  v = 32'h07F56EA6;
                5'd4:  v = 32'h03FEAB76;
                5'd5:  v = 32'h01FFD55B;
                5'd6:  v = 32'h00FFFAAA;
                5'd7:  v = 32'h007FFF55;
                5'd8:  v = 32'h003FFFEA;
                5'd9:  v = 32'h001FFFFD;
                5'd10: v = 32'h000FFFFF;
                5'd11: v = 32'h0007FFFF;
                5'd12: v = 32'h0003FFFF;
                5'd13: v = 32'h0001FFFF;
                5'd14: v = 32'h0000FFFF;
                5'd15: v = 32'h00007FFF;
                5'd16: v = 32'h00003FFF;
                5'd17: v = 32'h00001FFF;
                5'd18: v = 32'h00000FFF;
                5'd19: v = 32'h000007FF;
                5'd20: v = 32'h000003FF;
                5'd21: v = 32'h000001FF;
                5'd22: v = 32'h000000FF;
                5'd23: v = 32'h0000007F;
                5'd24: v = 32'h0000003F;
                5'd25: v = 32'h0000001F;
                5'd26: v = 32'h0000000F;
                5'd27: v = 32'h00000008;
                default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

endpackage

@@ src/apg_datapath.sv @@
// ----------------------------------------------------------------------------
// apg_datapath
// Angle reduction, span divider, shared CORDIC and the point multiplier.
// ----------------------------------------------------------------------------
module apg_datapath (
    input  logic                          clk,
    input  apg_pkg::dp_cmd_t              cmd,
    output apg_pkg::dp_stat_t             stat,
    input  logic signed [31:0]            center_x,
    input  logic signed [31:0]            center_y,
    input  logic signed [31:0]            radius,
    input  logic signed [23:0]            start_angle,
    input  logic signed [23:0]            end_angle,
    input  logic [6:0]                    num_points,
    output logic signed [31:0]            point_x,
    output logic signed [31:0]            point_y,
    output logic [apg_pkg::IDX_W-1:0]     point_index
);

    localparam int AW = apg_pkg::A_W;
    localparam int GW = apg_pkg::ANGC_W;
    localparam int XW = apg_pkg::CW;
    localparam int UW = apg_pkg::U_W;
    localparam int IW = apg_pkg::IDX_W;
    localparam int SW = apg_pkg::SPAN_W;

    localparam logic signed [GW-1:0] C_PI     = GW'(apg_pkg::PI_Q30);
    localparam logic signed [GW-1:0] C_TWO_PI = GW'(apg_pkg::TWO_PI_Q30);
    localparam logic signed [GW-1:0] C_HALF   = GW'(apg_pkg::HALF_PI_Q30);
    localparam logic signed [36:0]   SAT_MAX  = 37'sh007FFFFFFF;
    localparam logic signed [36:0]   SAT_MIN  = -37'sh0080000000;

    function automatic logic signed [35:0] rnd30(input logic signed [65:0] v);
        logic signed [65:0] t;
        begin
            t = v + 66'sd536870912;
            return t[65:30];
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        begin
            if (v > SAT_MAX)
                r = 32'sh7FFFFFFF;
            else if (v < SAT_MIN)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

    logic signed [31:0]   cx_reg, cy_reg, r_reg;
    logic [IW:0]          n_reg;
    logic [IW-1:0]        idx_reg;
    logic signed [AW-1:0] ang0_reg, ang1_reg;
    logic [AW-1:0]        mag_reg, spanw_reg;
    logic                 sneg_reg;
    logic [SW-1:0]        quo_reg;
    logic [IW-1:0]        rem_reg, div_reg;
    logic signed [GW-1:0] ca_reg;
    logic signed [XW-1:0] x_reg, y_reg;
    logic                 cneg_reg;
    logic signed [UW-1:0] sc_reg, ss_reg, ux_reg, uy_reg, nx_reg;
    logic signed [63:0]   prod_reg, acc_reg;
    logic signed [31:0]   px_reg, py_reg;

    logic signed [AW-1:0] w0, w1, a2;
    logic [AW-1:0]        mod_sub;
    logic [IW:0]          div_t;
    logic signed [31:0]   mul_a, mul_b;
    logic signed [63:0]   mul_p;
    logic [4:0]           ci;
    logic signed [XW-1:0] xs, ys;
    logic signed [XW-1:0] x_neg, y_neg;

    assign w0      = AW'(start_angle) <<< apg_pkg::WIDE_SH;
    assign w1      = AW'(end_angle) <<< apg_pkg::WIDE_SH;
    assign a2      = sneg_reg ? -$signed(mag_reg) : $signed(mag_reg);
    assign mod_sub = AW'(apg_pkg::TWO_PI_Q30) << cmd.iter;
    assign div_t   = {rem_reg, quo_reg[SW-1]};
    assign ci      = cmd.iter[4:0];
    assign xs      = x_reg >>> ci;
    assign ys      = y_reg >>> ci;
    assign x_neg   = -x_reg;
    assign y_neg   = -y_reg;

    always_comb
    begin
        case (cmd.iter[2:0])
            3'd0:    begin mul_a = ux_reg; mul_b = r_reg;  end
            3'd1:    begin mul_a = uy_reg; mul_b = r_reg;  end
            3'd2:    begin mul_a = ux_reg; mul_b = sc_reg; end
            3'd3:    begin mul_a = uy_reg; mul_b = ss_reg; end
            3'd4:    begin mul_a = ux_reg; mul_b = ss_reg; end
            3'd5:    begin mul_a = uy_reg; mul_b = sc_reg; end
            default: begin mul_a = ux_reg; mul_b = r_reg;  end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            apg_pkg::OP_LOAD:
            begin
                cx_reg   <= center_x;
                cy_reg   <= center_y;
                r_reg    <= radius;
                n_reg    <= (num_points > 7'(apg_pkg::MAX_POINTS))
                            ? (IW+1)'(apg_pkg::MAX_POINTS) : num_points[IW:0];
                idx_reg  <= '0;
                ang0_reg <= w0;
                ang1_reg <= w1;
                sneg_reg <= start_angle[23];
                mag_reg  <= start_angle[23] ? AW'(-w0) : AW'(w0);
            end
            apg_pkg::OP_MOD:
            begin
                if (mag_reg >= mod_sub)
                    mag_reg <= mag_reg - mod_sub;
            end
            apg_pkg::OP_ADJ0:
            begin
                ang1_reg <= ang1_reg + a2 - ang0_reg;
                ang0_reg <= a2;
            end
            apg_pkg::OP_ADJ1:
            begin
                if (ang1_reg < ang0_reg)
                begin
                    ang0_reg <= ang1_reg;
                    ang1_reg <= ang0_reg;
                end
            end
            apg_pkg::OP_ADJ2:
            begin
                spanw_reg <= AW'(ang1_reg - ang0_reg);
            end
            apg_pkg::OP_ADJ3:
            begin
                if (spanw_reg > AW'(apg_pkg::TWO_PI_Q30))
                begin
                    ang0_reg <= '0;
                    quo_reg  <= SW'(apg_pkg::TWO_PI_Q30);
                end
                else
                begin
                    quo_reg <= spanw_reg[SW-1:0];
                end
            end
            apg_pkg::OP_DIV_INIT:
            begin
                rem_reg <= '0;
                div_reg <= IW'(n_reg - 1'b1);
            end
            apg_pkg::OP_DIV:
            begin
                if (div_t >= {1'b0, div_reg})
                begin
                    rem_reg <= IW'(div_t - {1'b0, div_reg});
                    quo_reg <= {quo_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= div_t[IW-1:0];
                    quo_reg <= {quo_reg[SW-2:0], 1'b0};
                end
            end
            apg_pkg::OP_COR_STEP, apg_pkg::OP_COR_START:
            begin
                ca_reg   <= (cmd.op == apg_pkg::OP_COR_STEP) ? GW'(quo_reg)
                                                              : ang0_reg[GW-1:0];
                x_reg    <= XW'(apg_pkg::GAIN_INV);
                y_reg    <= '0;
                cneg_reg <= 1'b0;
            end
            apg_pkg::OP_COR_WRAP:
            begin
                if (ca_reg > C_PI)
                    ca_reg <= ca_reg - C_TWO_PI;
                else if (ca_reg < -C_PI)
                    ca_reg <= ca_reg + C_TWO_PI;
            end
            apg_pkg::OP_COR_FOLD:
            begin
                if (ca_reg > C_HALF)
                begin
                    ca_reg   <= ca_reg - C_PI;
                    cneg_reg <= 1'b1;
                end
                else if (ca_reg < -C_HALF)
                begin
                    ca_reg   <= ca_reg + C_PI;
                    cneg_reg <= 1'b1;
                end
            end
            apg_pkg::OP_COR_ITER:
            begin
                if (!ca_reg[GW-1])
                begin
                    x_reg  <= x_reg - ys;
                    y_reg  <= y_reg + xs;
                    ca_reg <= ca_reg - GW'(apg_pkg::atan_q30(ci));
                end
                else
                begin
                    x_reg  <= x_reg + ys;
                    y_reg  <= y_reg - xs;
                    ca_reg <= ca_reg + GW'(apg_pkg::atan_q30(ci));
                end
            end
            apg_pkg::OP_SAVE_ROT:
            begin
                sc_reg <= cneg_reg ? x_neg[UW-1:0] : x_reg[UW-1:0];
                ss_reg <= cneg_reg ? y_neg[UW-1:0] : y_reg[UW-1:0];
            end
            apg_pkg::OP_SAVE_UNIT:
            begin
                ux_reg <= cneg_reg ? x_neg[UW-1:0] : x_reg[UW-1:0];
                uy_reg <= cneg_reg ? y_neg[UW-1:0] : y_reg[UW-1:0];
            end
            apg_pkg::OP_POINT:
            begin
                prod_reg <= mul_p;
                case (cmd.iter[2:0])
                    3'd1: px_reg  <= sat32(37'(cx_reg) + 37'(rnd30(66'(prod_reg))));
                    3'd2: py_reg  <= sat32(37'(cy_reg) - 37'(rnd30(66'(prod_reg))));
                    3'd3: acc_reg <= prod_reg;
                    3'd4: nx_reg  <= UW'(rnd30(66'(acc_reg) - 66'(prod_reg)));
                    3'd5: acc_reg <= prod_reg;
                    3'd6:
                    begin
                        ux_reg <= nx_reg;
                        uy_reg <= UW'(rnd30(66'(acc_reg) + 66'(prod_reg)));
                    end
                    default: ;
                endcase
            end
            apg_pkg::OP_ADVANCE:
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            default: ;
        endcase
    end

    assign stat.n_zero = (n_reg == '0);
    assign stat.n_one  = (n_reg == (IW+1)'(1));
    assign stat.last   = (idx_reg == IW'(n_reg - 1'b1));

    assign point_x     = px_reg;
    assign point_y     = py_reg;
    assign point_index = idx_reg;

endmodule

@@ src/apg_controller.sv @@
// ----------------------------------------------------------------------------
// apg_controller
// Sequencer that steps the datapath through setup and point emission.
// ----------------------------------------------------------------------------
module apg_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  apg_pkg::dp_stat_t    stat,
    output apg_pkg::dp_cmd_t     cmd
);

    localparam int IW = apg_pkg::ITER_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_MOD   = 9'b000000100,
        S_ADJ   = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_CROT  = 9'b000100000,
        S_CUNIT = 9'b001000000,
        S_POINT = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    localparam logic [IW-1:0] CNT_ITER0 = IW'(4);
    localparam logic [IW-1:0] CNT_SAVE  = IW'(4 + apg_pkg::CORDIC_STEPS);

    state_t          state_reg, state_next;
    logic [IW-1:0]   cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg + 1'b1;
        cmd.op     = apg_pkg::OP_NONE;
        cmd.iter   = cnt_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cnt_next = '0;
                if (in_valid)
                begin
                    cmd.op     = apg_pkg::OP_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cnt_next   = IW'(apg_pkg::MOD_STEPS - 1);
                state_next = stat.n_zero ? S_IDLE : S_MOD;
            end
            S_MOD:
            begin
                cmd.op   = apg_pkg::OP_MOD;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = '0;
                    state_next = S_ADJ;
                end
            end
            S_ADJ:
            begin
                case (cnt_reg[1:0])
                    2'd0:    cmd.op = apg_pkg::OP_ADJ0;
                    2'd1:    cmd.op = apg_pkg::OP_ADJ1;
                    2'd2:    cmd.op = apg_pkg::OP_ADJ2;
                    default: cmd.op = apg_pkg::OP_ADJ3;
                endcase
                if (cnt_reg[1:0] == 2'd3)
                begin
                    cnt_next   = '0;
                    state_next = stat.n_one ? S_CUNIT : S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op = (cnt_reg == '0) ? apg_pkg::OP_DIV_INIT : apg_pkg::OP_DIV;
                if (cnt_reg == IW'(apg_pkg::SPAN_W))
                begin
                    cnt_next   = '0;
                    state_next = S_CROT;
                end
            end
            S_CROT, S_CUNIT:
            begin
                cmd.iter = cnt_reg - CNT_ITER0;
                if (cnt_reg == '0)
                    cmd.op = (state_reg == S_CROT) ? apg_pkg::OP_COR_STEP
                                                   : apg_pkg::OP_COR_START;
                else if (cnt_reg < IW'(3))
                    cmd.op = apg_pkg::OP_COR_WRAP;
                else if (cnt_reg == IW'(3))
                    cmd.op = apg_pkg::OP_COR_FOLD;
                else if (cnt_reg < CNT_SAVE)
                    cmd.op = apg_pkg::OP_COR_ITER;
                else
                begin
                    cmd.op     = (state_reg == S_CROT) ? apg_pkg::OP_SAVE_ROT
                                                       : apg_pkg::OP_SAVE_UNIT;
                    cnt_next   = '0;
                    state_next = (state_reg == S_CROT) ? S_CUNIT : S_POINT;
                end
            end
            S_POINT:
            begin
                cmd.op = apg_pkg::OP_POINT;
                if (cnt_reg == IW'(6))
                begin
                    cnt_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                cnt_next  = '0;
                if (out_ready)
                begin
                    cmd.op     = apg_pkg::OP_ADVANCE;
                    state_next = stat.last ? S_IDLE : S_POINT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ src/arc_point_generator_top.sv @@
// ----------------------------------------------------------------------------
// arc_point_generator_top
// Arc tessellation: one request in, one result per point out.
// ----------------------------------------------------------------------------
// A request occupies the block for setup, then for each point the POINT and
// OUT states plus any wait on out_ready. Setup runs the restoring angle
// reduction (one conditional subtract of a shifted multiple of two pi a
// cycle), the bit-serial span divider (one quotient bit a cycle) and two
// passes through a single 28-step CORDIC; the divider and the first pass are
// skipped when one point is asked for. Each point then goes through one shared
// 32 by 32 multiplier six times: two radius products and four for the rotation
// of the unit vector. A new request is taken only once the last point of the
// previous arc has been delivered; a count of zero produces no points.
module arc_point_generator_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [31:0]                center_x,
    input  logic signed [31:0]                center_y,
    input  logic signed [31:0]                radius,
    input  logic signed [23:0]                start_angle,
    input  logic signed [23:0]                end_angle,
    input  logic [6:0]                        num_points,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [31:0]                point_x,
    output logic signed [31:0]                point_y,
    output logic [apg_pkg::IDX_W-1:0]         point_index,
    output logic                              last
);

    // Command and status between the sequencer and the datapath.
    apg_pkg::dp_cmd_t  cmd;
    apg_pkg::dp_stat_t stat;

    apg_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    apg_datapath u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .stat        (stat),
        .center_x    (center_x),
        .center_y    (center_y),
        .radius      (radius),
        .start_angle (start_angle),
        .end_angle   (end_angle),
        .num_points  (num_points),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_index (point_index)
    );

    // The final point of the arc carries the last flag.
    assign last = stat.last;

endmodule

@@ src/apg_checker.sv @@
// ----------------------------------------------------------------------------
// apg_checker
// Port-level checks of the arc point generator, bound to the top level.
// ----------------------------------------------------------------------------
module apg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] point_x,
    input logic        last
);

    // A request is never taken while a point is on offer.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("request accepted while a point is pending");

    // No point is offered right after a request is taken.
    a_no_fast_out: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !out_valid)
        else $error("point offered right after request");

    // After the final point the block is free for a new request.
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> in_ready)
        else $error("block not free after final point");

    // A stalled point holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(point_x)))
        else $error("stalled point changed");

endmodule

bind arc_point_generator_top apg_checker u_apg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .point_x   (point_x),
    .last      (last)
);

@@ tb/arc_point_generator_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// arc_point_generator_top_tb
// Self-checking testbench for the arc point generator. Arc requests are sent
// from directed tests and then random tests under varying handshake pressure.
// A built-in predictor computes the points of each arc, and every point that
// comes out of the block is compared against the oldest predicted point.
// ----------------------------------------------------------------------------
module arc_point_generator_top_tb;

    // Q2.30 angle constants, rounded to nearest.
    localparam longint TWO_PI_A  = 64'sd6746518852;
    localparam longint PI_A      = 64'sd3373259426;
    localparam longint HALF_PI_A = 64'sd1686629713;
    localparam longint GAIN_A    = 64'sd652032874;
    localparam longint ROUND_A   = 64'sd536870912;
    localparam int     WATCHDOG  = 40000;

    // One predicted point of an arc.
    typedef struct {
        logic signed [31:0]        px;
        logic signed [31:0]        py;
        logic [apg_pkg::IDX_W-1:0] idx;
        logic                      lst;
    } arc_point_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] radius;
    logic signed [23:0] start_angle;
    logic signed [23:0] end_angle;
    logic [6:0] num_points;
    logic out_valid;
    logic out_ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [apg_pkg::IDX_W-1:0] point_index;
    logic last;

    arc_point_t pending_points[$];
    int  fail_count;
    int  arcs_sent;
    int  points_seen;
    int  idle_cycles;
    int  send_gap_pct;
    int  recv_stall_pct;

    arc_point_generator_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .center_x    (center_x),
        .center_y    (center_y),
        .radius      (radius),
        .start_angle (start_angle),
        .end_angle   (end_angle),
        .num_points  (num_points),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .point_index (point_index),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Arctangent of 2^-i in Q2.30, kept separate from the package function.
    function automatic longint arctan_step(input int i);
        longint tbl[28];
        begin
            tbl = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
                    64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
                    64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
                    64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
                    64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
                    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
                    64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008};
            return tbl[i];
        end
    endfunction

    function automatic longint round_unit(input longint v);
        begin
            return (v + ROUND_A) >>> 30;
        end
    endfunction

    function automatic logic signed [31:0] clamp_coord(input longint v);
        begin
            if (v > 64'sd2147483647)
                return 32'sh7FFFFFFF;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return v[31:0];
        end
    endfunction

    // CORDIC rotation: the angle is wrapped into [-pi, pi] and folded into
    // [-pi/2, pi/2], folding negates the resulting vector.
    task automatic cordic_unit(input longint ang, output longint c, output longint s);
        longint x;
        longint y;
        longint t;
        bit     flip;
        begin
            x = GAIN_A;
            y = 0;
            flip = 0;
            while (ang > PI_A)
                ang -= TWO_PI_A;
            while (ang < -PI_A)
                ang += TWO_PI_A;
            if (ang > HALF_PI_A)
            begin
                ang -= PI_A;
                flip = 1;
            end
            else if (ang < -HALF_PI_A)
            begin
                ang += PI_A;
                flip = 1;
            end
            for (int i = 0; i < 28; i++)
            begin
                if (ang >= 0)
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    ang -= arctan_step(i);
                end
                else
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    ang += arctan_step(i);
                end
                x = t;
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        end
    endtask

    // Works out every point of one arc and queues them.
    task automatic predict_arc_points(input logic signed [31:0] cx,
                                      input logic signed [31:0] cy,
                                      input logic signed [31:0] r,
                                      input logic signed [23:0] sa,
                                      input logic signed [23:0] ea, input logic [6:0] cnt);
        longint a0, a1, red, tmp, step, sc, ss, ux, uy, nx, ny, n;
        arc_point_t p;
        begin
            n = cnt;
            if (n == 0)
                return;
            if (n > apg_pkg::MAX_POINTS)
                n = apg_pkg::MAX_POINTS;
            a0 = longint'(sa) <<< (30 - apg_pkg::FRAC_BITS);
            a1 = longint'(ea) <<< (30 - apg_pkg::FRAC_BITS);
            red = a0 % TWO_PI_A;
            a1 += red - a0;
            a0 = red;
            if (a1 < a0)
            begin
                tmp = a0;
                a0 = a1;
                a1 = tmp;
            end
            if (a1 - a0 > TWO_PI_A)
            begin
                a0 = 0;
                a1 = TWO_PI_A;
            end
            sc = 0;
            ss = 0;
            if (n > 1)
            begin
                step = (a1 - a0) / (n - 1);
                cordic_unit(step, sc, ss);
            end
            cordic_unit(a0, ux, uy);
            for (longint i = 0; i < n; i++)
            begin
                p.px  = clamp_coord(longint'(cx) + round_unit(ux * longint'(r)));
                p.py  = clamp_coord(longint'(cy) - round_unit(uy * longint'(r)));
                p.idx = i[apg_pkg::IDX_W-1:0];
                p.lst = (i + 1 == n);
                pending_points.push_back(p);
                nx = round_unit(ux * sc - uy * ss);
                ny = round_unit(ux * ss + uy * sc);
                ux = nx;
                uy = ny;
            end
        end
    endtask

    // Sends one arc request, predicting its points at acceptance. Valid is
    // dropped only for an idle gap, so a following request can go straight on.
    task automatic send_arc(input logic signed [31:0] cx, input logic signed [31:0] cy,
                            input logic signed [31:0] r, input logic signed [23:0] sa,
                            input logic signed [23:0] ea, input logic [6:0] cnt);
        begin
            while ($urandom_range(99) < send_gap_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid    <= 1'b1;
            center_x    <= cx;
            center_y    <= cy;
            radius      <= r;
            start_angle <= sa;
            end_angle   <= ea;
            num_points  <= cnt;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            predict_arc_points(cx, cy, r, sa, ea, cnt);
            arcs_sent++;
        end
    endtask

    // Receiver: random stalls and comparison of every accepted point.
    always @(posedge clk)
    begin
        arc_point_t exp_pt;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                points_seen++;
                if (pending_points.size() == 0)
                begin
                    $error("unexpected point x=%0d y=%0d index=%0d", point_x, point_y,
                           point_index);
                    fail_count++;
                end
                else
                begin
                    exp_pt = pending_points.pop_front();
                    if (point_x !== exp_pt.px)
                    begin
                        $error("point_x expected %0d actual %0d", exp_pt.px, point_x);
                        fail_count++;
                    end
                    if (point_y !== exp_pt.py)
                    begin
                        $error("point_y expected %0d actual %0d", exp_pt.py, point_y);
                        fail_count++;
                    end
                    if (point_index !== exp_pt.idx)
                    begin
                        $error("point_index expected %0d actual %0d", exp_pt.idx,
                               point_index);
                        fail_count++;
                    end
                    if (last !== exp_pt.lst)
                    begin
                        $error("last expected %0d actual %0d", exp_pt.lst, last);
                        fail_count++;
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: counts cycles in which neither channel accepts anything.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("timeout with %0d points outstanding", pending_points.size());
            $display("arc_point_generator_top test failed");
            $finish;
        end
    end

    function automatic logic signed [23:0] rand_angle();
        begin
            case ($urandom_range(3))
                0: return 24'($urandom);
                1: return $signed(24'($urandom_range(0, 900000))) - 24'sd450000;
                2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
                default: return $signed(24'($urandom_range(0, 2 * 411775))) - 24'sd411775;
            endcase
        end
    endfunction

    function automatic logic signed [31:0] rand_coord();
        begin
            if ($urandom_range(3) == 0)
                return $urandom;
            return $signed(32'($urandom_range(0, 32'h0FFFFFFF))) - 32'sh08000000;
        end
    endfunction

    // Mostly small counts to keep runs short, a few at or over the maximum.
    function automatic logic [6:0] rand_count();
        begin
            case ($urandom_range(9))
                0: return 7'($urandom_range(64, 127));
                1: return 7'($urandom_range(0, 2));
                default: return 7'($urandom_range(1, 12));
            endcase
        end
    endfunction

    // Extremes of every field and each special case: zero, one and clamped
    // counts, reversed angles, spans beyond two pi and coordinate saturation.
    task automatic test_directed_arcs();
        begin
            send_arc(0, 0, 32'sh00010000, 0, 24'sd102944, 5);
            send_arc(0, 0, 32'sh00010000, 24'sd102944, 0, 4);
            send_arc(32'sh00100000, 0, 32'sh00200000, 24'sd50000, 24'sd50000, 1);
            send_arc(0, 0, 32'sh00010000, 0, 24'sd100000, 0);
            send_arc(0, 0, 32'sh7FFFFFFF, 24'sh7FFFFF, 24'sh800000, 127);
            send_arc(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 0, 24'sd411775, 9);
            send_arc(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 24'sh800000,
                     24'sh7FFFFF, 65);
            send_arc(32'shFFFFFFFF, 32'shFFFFFFFF, 32'shFFFFFFFF, 24'shFFFFFF,
                     24'shFFFFFF, 2);
            send_arc(0, 0, 32'sh00050000, -24'sd500000, 24'sd300000, 7);
            send_arc(0, 0, 32'sh00050000, 24'sd411775, -24'sd411775, 3);
            send_arc(0, 0, 32'sh00050000, 24'sd411776, 24'sd823550, 64);
            send_arc(0, 0, -32'sh00050000, 24'sd205887, 24'sd308831, 6);
            send_arc(32'sh12345678, 32'shEDCBA987, 32'sh00000000, 24'sd1, 24'sd2, 2);
            send_arc(0, 0, 32'sh40000000, 24'sd102944, 24'sd308831, 2);
            send_arc(0, 0, 32'sh00010000, 24'sh555555, 24'shAAAAAA, 8);
        end
    endtask

    task automatic test_random_arcs(input int count);
        logic signed [23:0] sa;
        logic signed [23:0] ea;
        begin
            for (int k = 0; k < count; k++)
            begin
                sa = rand_angle();
                if ($urandom_range(1))
                    ea = rand_angle();
                else
                    ea = sa + $signed(24'($urandom_range(0, 900000))) - 24'sd300000;
                send_arc(rand_coord(), rand_coord(), rand_coord(), sa, ea, rand_count());
            end
        end
    endtask

    task automatic drain_points();
        begin
            in_valid <= 1'b0;
            while (pending_points.size() != 0)
                @(posedge clk);
            repeat (200) @(posedge clk);
        end
    endtask

    initial
    begin
        fail_count     = 0;
        arcs_sent      = 0;
        points_seen    = 0;
        idle_cycles    = 0;
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_ready      = 1'b0;
        center_x       = '0;
        center_y       = '0;
        radius         = '0;
        start_angle    = '0;
        end_angle      = '0;
        num_points     = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_arcs();
        send_gap_pct   = 32;
        recv_stall_pct = 73;
        test_random_arcs(150);
        send_gap_pct   = 73;
        recv_stall_pct = 32;
        test_random_arcs(150);
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_random_arcs(155);
        drain_points();

        $display("Covered %0d arc requests and %0d points under three handshake patterns.",
                 arcs_sent, points_seen);
        if (fail_count == 0)
            $display("arc_point_generator_top test passed");
        else
            $display("arc_point_generator_top test failed");
        $finish;
    end

endmodule
